>>> hw/rtl/iarl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iarl_pkg
// Shared types and constants of the indexed array list unit.
// ----------------------------------------------------------------------------
package iarl_pkg;

	localparam int DATA_W  = 32;
	localparam int INDEX_W = 9;
	localparam int LEN_W   = 9;
	localparam int TDATA_W = 48;

	typedef enum logic [2:0] {
		OP_PUSH   = 3'd0,
		OP_POP    = 3'd1,
		OP_READ   = 3'd2,
		OP_WRITE  = 3'd3,
		OP_INSERT = 3'd4,
		OP_ERASE  = 3'd5,
		OP_CLEAR  = 3'd6,
		OP_RESIZE = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_INDEX = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

endpackage
`default_nettype wire

>>> hw/rtl/indexed_array_list_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_array_list_unit
// Fixed-capacity list of signed words held in one RAM, with push, pop, read,
// write, insert, erase, clear and resize. One result beat per request beat.
// ----------------------------------------------------------------------------
//  channel   dir  fields (tdata, lowest bit first)
//  s_axis    in   op[2:0], index[11:3], value[43:12], zero pad to 48 bits
//  m_axis    out  data[31:0], status[33:32], length[42:34], zero pad to 48
//
//  A request is taken one at a time. Push, write, clear, shrink, erase of the
//  last entry and errors answer straight from the execute state; pop and read
//  wait for the registered RAM read; insert, any other erase and grow walk the
//  entries through the shift or fill states over the single RAM port pair,
//  one entry moved or filled per cycle.
//  The RAM contents are not cleared by reset; only the length is. A stalled
//  result waits in the output register and a new request is taken in the cycle
//  it leaves.
// ----------------------------------------------------------------------------
module indexed_array_list_unit #(
	parameter int CAPACITY = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [iarl_pkg::TDATA_W-1:0]  s_axis_tdata,  // op, index, value
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic      [iarl_pkg::TDATA_W-1:0]  m_axis_tdata   // data, status, length
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CW > iarl_pkg::INDEX_W) ? CW : iarl_pkg::INDEX_W;
	localparam logic [IW-1:0] CAP_W = IW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RDWAIT,
		S_SHIFT,
		S_DRAIN,
		S_INSFIN,
		S_FILL
	} state_t;

	state_t state_q;

	iarl_pkg::op_t                 op_q;
	logic [iarl_pkg::INDEX_W-1:0]  idx_q;
	logic [iarl_pkg::DATA_W-1:0]   val_q;
	logic [CW-1:0]                 count_q;
	logic [AW-1:0]                 src_q;
	logic [AW-1:0]                 end_q;
	logic                          up_q;
	logic                          pend_s1;
	logic [AW-1:0]                 dst_s1;

	logic                          out_valid_q;
	logic [iarl_pkg::DATA_W-1:0]   data_q;
	iarl_pkg::status_t             status_q;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [iarl_pkg::DATA_W-1:0]   ram_wdata;
	logic [AW-1:0]                 ram_raddr;
	logic [iarl_pkg::DATA_W-1:0]   ram_rdata;

	logic [IW-1:0] idx_w;
	logic [IW-1:0] cnt_w;
	logic [CW-1:0] cnt_m1;
	logic          idx_ok;
	logic          is_full;
	logic          accept;
	logic          fill_last;

	assign idx_w     = IW'(idx_q);
	assign cnt_w     = IW'(count_q);
	assign cnt_m1    = count_q - CW'(1);
	assign idx_ok    = idx_w < cnt_w;
	assign is_full   = cnt_w == CAP_W;
	assign fill_last = (IW'(src_q) + IW'(1)) == idx_w;

	assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		{(iarl_pkg::TDATA_W - iarl_pkg::DATA_W - 2 - iarl_pkg::LEN_W){1'b0}},
		iarl_pkg::LEN_W'(count_q),
		status_q,
		data_q
	};

	iarl_ram #(
		.WIDTH (iarl_pkg::DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = dst_s1;
		ram_wdata = val_q;
		ram_raddr = src_q;
		unique case (state_q)
			S_EXEC: begin
				case (op_q)
					iarl_pkg::OP_PUSH: begin
						ram_we    = !is_full;
						ram_waddr = AW'(count_q);
					end
					iarl_pkg::OP_POP: begin
						ram_raddr = AW'(cnt_m1);
					end
					iarl_pkg::OP_READ: begin
						ram_raddr = AW'(idx_w);
					end
					iarl_pkg::OP_WRITE: begin
						ram_we    = idx_ok;
						ram_waddr = AW'(idx_w);
					end
					default: begin
					end
				endcase
			end
			S_SHIFT, S_DRAIN: begin
				// The word read last cycle lands one slot up (insert) or down (erase).
				ram_we    = pend_s1;
				ram_wdata = ram_rdata;
			end
			S_INSFIN: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(idx_w);
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = src_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
			status_q    <= iarl_pkg::ST_OK;
			data_q      <= '0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= iarl_pkg::op_t'(s_axis_tdata[2:0]);
						idx_q   <= s_axis_tdata[11:3];
						val_q   <= s_axis_tdata[43:12];
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					data_q      <= '0;
					status_q    <= iarl_pkg::ST_OK;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
					pend_s1     <= 1'b0;
					case (op_q)
						iarl_pkg::OP_PUSH: begin
							if (is_full) begin
								status_q <= iarl_pkg::ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end
						iarl_pkg::OP_POP: begin
							if (count_q == '0) begin
								status_q <= iarl_pkg::ST_EMPTY;
							end else begin
								count_q     <= cnt_m1;
								out_valid_q <= 1'b0;
								state_q     <= S_RDWAIT;
							end
						end
						iarl_pkg::OP_READ: begin
							if (!idx_ok) begin
								status_q <= iarl_pkg::ST_BAD_INDEX;
							end else begin
								out_valid_q <= 1'b0;
								state_q     <= S_RDWAIT;
							end
						end
						iarl_pkg::OP_WRITE: begin
							if (!idx_ok) begin
								status_q <= iarl_pkg::ST_BAD_INDEX;
							end
						end
						iarl_pkg::OP_INSERT: begin
							if (!idx_ok) begin
								status_q <= iarl_pkg::ST_BAD_INDEX;
							end else if (is_full) begin
								status_q <= iarl_pkg::ST_FULL;
							end else begin
								count_q     <= count_q + CW'(1);
								src_q       <= AW'(cnt_m1);
								end_q       <= AW'(idx_w);
								up_q        <= 1'b1;
								out_valid_q <= 1'b0;
								state_q     <= S_SHIFT;
							end
						end
						iarl_pkg::OP_ERASE: begin
							if (!idx_ok) begin
								status_q <= iarl_pkg::ST_BAD_INDEX;
							end else begin
								count_q <= cnt_m1;
								// Erasing the last entry moves nothing.
								if (idx_w != IW'(cnt_m1)) begin
									src_q       <= AW'(idx_w + IW'(1));
									end_q       <= AW'(cnt_m1);
									up_q        <= 1'b0;
									out_valid_q <= 1'b0;
									state_q     <= S_SHIFT;
								end
							end
						end
						iarl_pkg::OP_CLEAR: begin
							count_q <= '0;
						end
						default: begin
							if (idx_w < cnt_w) begin
								count_q <= CW'(idx_w);
							end else if (idx_w > cnt_w) begin
								if (idx_w > CAP_W) begin
									status_q <= iarl_pkg::ST_FULL;
								end else begin
									src_q       <= AW'(count_q);
									out_valid_q <= 1'b0;
									state_q     <= S_FILL;
								end
							end
						end
					endcase
				end
				S_RDWAIT: begin
					data_q      <= ram_rdata;
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SHIFT: begin
					pend_s1 <= 1'b1;
					dst_s1  <= up_q ? src_q + AW'(1) : src_q - AW'(1);
					if (src_q == end_q) begin
						state_q <= S_DRAIN;
					end else begin
						src_q <= up_q ? src_q - AW'(1) : src_q + AW'(1);
					end
				end
				S_DRAIN: begin
					pend_s1 <= 1'b0;
					if (up_q) begin
						state_q <= S_INSFIN;
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_INSFIN: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_FILL: begin
					if (fill_last) begin
						count_q     <= CW'(idx_w);
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						src_q <= src_q + AW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The length never goes beyond the capacity.
	assert property (@(posedge clk) disable iff (!arst_n)
		IW'(count_q) <= CAP_W)
		else $error("list length exceeds capacity");

	// A result only appears as the unit returns to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> state_q == S_IDLE)
		else $error("result raised while an operation is still running");

	// Failed operations never return data.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != iarl_pkg::ST_OK |-> data_q == '0)
		else $error("error result carries nonzero data");

	// No new request is taken while the result register holds an unread beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !out_valid_q || m_axis_tready)
		else $error("request accepted over a pending result");

endmodule
`default_nettype wire

>>> hw/rtl/iarl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iarl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module iarl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> bench/tb_indexed_array_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_array_list_unit
// Self-checking bench for the indexed array list unit. A short directed run
// hits the empty, full and bad-position corners of the operations, then two
// halves of random operations follow, with the length kept mostly small. A
// software copy of the list predicts one result beat per request beat, and
// the monitor compares data, status and length field by field.
// ----------------------------------------------------------------------------
module tb_indexed_array_list_unit;

	localparam int CAPACITY   = 256;
	localparam int IDLE_LIMIT = 4000;
	localparam int TAIL       = 300;
	localparam int LONG_HOLD  = 400;
	localparam int MAX_PRINTS = 50;

	typedef struct packed {
		iarl_pkg::op_t      op;
		logic [8:0]         index;
		logic signed [31:0] value;
	} list_req_t;

	typedef struct packed {
		logic signed [31:0] data;
		iarl_pkg::status_t  status;
		logic [8:0]         length;
	} list_result_t;

	logic                          clk           = 1'b0;
	logic                          arst_n        = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [iarl_pkg::TDATA_W-1:0]  s_axis_tdata  = '0;  // op[2:0], index[11:3], value[43:12]
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [iarl_pkg::TDATA_W-1:0]  m_axis_tdata;  // data[31:0], status[33:32], length[42:34]

	indexed_array_list_unit #(
		.CAPACITY(CAPACITY)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	// Predicted list contents and length.
	logic signed [31:0] list_words [CAPACITY];
	int                 list_len = 0;

	list_req_t    pending_reqs [$];
	list_result_t awaited_results [$];

	int gen_len     = 0;
	int n_queued    = 0;
	int n_accepted  = 0;
	int n_checked   = 0;
	int n_errors    = 0;
	int ops_seen    [8] = '{default: 0};
	int status_seen [4] = '{default: 0};

	task automatic report(string msg);
		if (n_errors < MAX_PRINTS)
			$display("ERROR at %0t: %s", $realtime, msg);
		n_errors++;
	endtask

	function automatic int length_after(iarl_pkg::op_t op, int idx, int len);
		case (op)
			iarl_pkg::OP_PUSH:   return (len < CAPACITY) ? len + 1 : len;
			iarl_pkg::OP_POP:    return (len > 0) ? len - 1 : len;
			iarl_pkg::OP_INSERT: return (idx < len && len < CAPACITY) ? len + 1 : len;
			iarl_pkg::OP_ERASE:  return (idx < len) ? len - 1 : len;
			iarl_pkg::OP_CLEAR:  return 0;
			iarl_pkg::OP_RESIZE: return (idx <= CAPACITY) ? idx : len;
			default:             return len;
		endcase
	endfunction

	// Applies one request to the predicted list and returns the result beat.
	function automatic list_result_t apply_request(list_req_t r);
		list_result_t res;
		int           idx;
		int           i;
		idx        = int'(r.index);
		res.data   = '0;
		res.status = iarl_pkg::ST_OK;
		case (r.op)
			iarl_pkg::OP_PUSH: begin
				if (list_len >= CAPACITY) res.status = iarl_pkg::ST_FULL;
				else list_words[list_len] = r.value;
			end
			iarl_pkg::OP_POP: begin
				if (list_len == 0) res.status = iarl_pkg::ST_EMPTY;
				else res.data = list_words[list_len - 1];
			end
			iarl_pkg::OP_READ: begin
				if (idx >= list_len) res.status = iarl_pkg::ST_BAD_INDEX;
				else res.data = list_words[idx];
			end
			iarl_pkg::OP_WRITE: begin
				if (idx >= list_len) res.status = iarl_pkg::ST_BAD_INDEX;
				else list_words[idx] = r.value;
			end
			iarl_pkg::OP_INSERT: begin
				// The position check wins over the full check.
				if (idx >= list_len) res.status = iarl_pkg::ST_BAD_INDEX;
				else if (list_len >= CAPACITY) res.status = iarl_pkg::ST_FULL;
				else begin
					for (i = list_len; i > idx; i--)
						list_words[i] = list_words[i - 1];
					list_words[idx] = r.value;
				end
			end
			iarl_pkg::OP_ERASE: begin
				if (idx >= list_len) res.status = iarl_pkg::ST_BAD_INDEX;
				else begin
					for (i = idx; i < list_len - 1; i++)
						list_words[i] = list_words[i + 1];
				end
			end
			iarl_pkg::OP_CLEAR: begin
			end
			iarl_pkg::OP_RESIZE: begin
				if (idx > CAPACITY) res.status = iarl_pkg::ST_FULL;
				else begin
					for (i = list_len; i < idx; i++)
						list_words[i] = r.value;
				end
			end
			default: begin
			end
		endcase
		list_len   = length_after(r.op, idx, list_len);
		res.length = list_len[8:0];
		return res;
	endfunction

	task automatic add_item(iarl_pkg::op_t op, int idx, logic [31:0] v);
		list_req_t q;
		q.op    = op;
		q.index = idx[8:0];
		q.value = v;
		pending_reqs.insert(pending_reqs.size(), q);
		gen_len = length_after(op, idx, gen_len);
		n_queued++;
	endtask

	// Mostly valid positions, some just past the end, a few anywhere in 9 bits.
	function automatic int pick_index(int len);
		int r;
		r = $urandom_range(0, 9);
		if (len > 0 && r < 7) return $urandom_range(0, len - 1);
		if (r == 9) return $urandom_range(0, 511);
		return len + $urandom_range(0, 2);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 19))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_random(int n);
		int            k;
		int            r;
		int            s;
		int            idx;
		iarl_pkg::op_t op;
		logic [31:0]   v;
		for (k = 0; k < n; k++) begin
			r   = $urandom_range(0, 99);
			v   = pick_value();
			idx = pick_index(gen_len);
			if (gen_len > 40 && r < 30) begin
				// Long lists make every shift slow, so cut them back often.
				op  = iarl_pkg::OP_RESIZE;
				idx = $urandom_range(0, 16);
			end else if (r < 22) op = iarl_pkg::OP_PUSH;
			else if (r < 34) op = iarl_pkg::OP_POP;
			else if (r < 50) op = iarl_pkg::OP_READ;
			else if (r < 64) op = iarl_pkg::OP_WRITE;
			else if (r < 76) op = iarl_pkg::OP_INSERT;
			else if (r < 86) op = iarl_pkg::OP_ERASE;
			else if (r < 88) op = iarl_pkg::OP_CLEAR;
			else begin
				op = iarl_pkg::OP_RESIZE;
				s  = $urandom_range(0, 19);
				if (s < 12) idx = $urandom_range(0, gen_len + 8);
				else if (s < 16) idx = $urandom_range(0, 64);
				else if (s < 18) idx = $urandom_range(240, CAPACITY);
				else idx = $urandom_range(CAPACITY + 1, 511);
			end
			add_item(op, idx, v);
		end
	endtask

	task automatic wait_all_results();
		while (n_checked < n_queued) @(posedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps.
	list_req_t cur_req;
	int        burst_left;
	int        gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			burst_left    = 1;
			gap_left      = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				awaited_results.insert(awaited_results.size(), apply_request(cur_req));
				ops_seen[cur_req.op]++;
				n_accepted++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// Beat stays on the bus until it is taken.
			end else if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				cur_req = pending_reqs.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {4'b0, cur_req.value, cur_req.index, cur_req.op};
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
					                                         : $urandom_range(1, 24);
					gap_left   = $urandom_range(1, 12);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: changing stall modes, plus one long hold-off to back up the input.
	int  rx_mode;
	int  rx_mode_left;
	int  hold_left;
	bit  hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_mode      = 0;
			rx_mode_left = 0;
			hold_left    = 0;
			hold_done    = 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && n_checked >= 300) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			m_axis_tready <= 1'b0;
		end else begin
			if (rx_mode_left <= 0) begin
				rx_mode      = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(20, 300);
			end
			rx_mode_left--;
			case (rx_mode)
				0:       m_axis_tready <= 1'b1;
				1:       m_axis_tready <= $urandom_range(0, 1);
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Monitor: every result beat is checked against the oldest prediction.
	list_result_t got;
	list_result_t want;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.data   = m_axis_tdata[31:0];
			got.status = iarl_pkg::status_t'(m_axis_tdata[33:32]);
			got.length = m_axis_tdata[42:34];
			if (awaited_results.size() == 0) begin
				report($sformatf("result beat %0d with no request outstanding", n_checked));
			end else begin
				want = awaited_results.pop_front();
				if (got.data !== want.data)
					report($sformatf("result %0d data %0h, predicted %0h",
					                 n_checked, got.data, want.data));
				if (got.status !== want.status)
					report($sformatf("result %0d status %0d, predicted %0d",
					                 n_checked, got.status, want.status));
				if (got.length !== want.length)
					report($sformatf("result %0d length %0d, predicted %0d",
					                 n_checked, got.length, want.length));
			end
			status_seen[got.status]++;
			n_checked++;
		end
	end

	// Watchdog on cycles in which no beat moves on either side.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
				$display("tb_indexed_array_list_unit NOT OK");
				$finish;
			end
		end
	end

	initial begin
		// Corners on an empty list.
		add_item(iarl_pkg::OP_POP,    0, 32'h1234_5678);
		add_item(iarl_pkg::OP_READ,   0, 32'h0);
		add_item(iarl_pkg::OP_WRITE,  0, 32'h5555_5555);
		add_item(iarl_pkg::OP_INSERT, 0, 32'h6666_6666);
		add_item(iarl_pkg::OP_ERASE,  0, 32'h0);
		// A short list with the signed extremes.
		add_item(iarl_pkg::OP_PUSH,   0, 32'h7fff_ffff);
		add_item(iarl_pkg::OP_PUSH,   0, 32'h8000_0000);
		add_item(iarl_pkg::OP_INSERT, 0, 32'h0000_0001);
		add_item(iarl_pkg::OP_INSERT, 3, 32'h0000_0002);  // insert cannot append
		add_item(iarl_pkg::OP_READ,   2, 32'h0);
		add_item(iarl_pkg::OP_WRITE,  1, 32'hffff_ffff);
		add_item(iarl_pkg::OP_ERASE,  1, 32'h0);
		add_item(iarl_pkg::OP_RESIZE, 2, 32'h0);           // same length
		add_item(iarl_pkg::OP_RESIZE, CAPACITY + 1, 32'h0);
		// Grow to full and probe the full list.
		add_item(iarl_pkg::OP_RESIZE, CAPACITY, 32'ha5a5_a5a5);
		add_item(iarl_pkg::OP_PUSH,   0, 32'h0bad_0bad);
		add_item(iarl_pkg::OP_INSERT, 0, 32'h0bad_0bad);
		add_item(iarl_pkg::OP_INSERT, CAPACITY, 32'h0bad_0bad);
		add_item(iarl_pkg::OP_READ,   CAPACITY - 1, 32'h0);
		add_item(iarl_pkg::OP_ERASE,  CAPACITY - 1, 32'h0);
		add_item(iarl_pkg::OP_INSERT, 100, 32'h5a5a_5a5a);
		add_item(iarl_pkg::OP_RESIZE, 511, 32'h0);
		add_item(iarl_pkg::OP_RESIZE, 1, 32'h0);
		add_item(iarl_pkg::OP_POP,    0, 32'h0);
		add_item(iarl_pkg::OP_CLEAR,  0, 32'h0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The sender pauses here until the list has answered everything.
		wait_all_results();
		add_random(575);
		wait_all_results();
		add_random(575);
		wait_all_results();
		repeat (TAIL) @(posedge clk);
		if (awaited_results.size() != 0)
			report($sformatf("%0d predicted results never arrived", awaited_results.size()));

		$display("covered %0d requests: push %0d pop %0d read %0d write %0d insert %0d",
		         n_accepted, ops_seen[iarl_pkg::OP_PUSH], ops_seen[iarl_pkg::OP_POP],
		         ops_seen[iarl_pkg::OP_READ], ops_seen[iarl_pkg::OP_WRITE],
		         ops_seen[iarl_pkg::OP_INSERT]);
		$display("erase %0d clear %0d resize %0d; status ok %0d bad %0d empty %0d full %0d",
		         ops_seen[iarl_pkg::OP_ERASE], ops_seen[iarl_pkg::OP_CLEAR],
		         ops_seen[iarl_pkg::OP_RESIZE], status_seen[iarl_pkg::ST_OK],
		         status_seen[iarl_pkg::ST_BAD_INDEX], status_seen[iarl_pkg::ST_EMPTY],
		         status_seen[iarl_pkg::ST_FULL]);
		if (n_errors == 0) begin
			$display("tb_indexed_array_list_unit OK");
		end else begin
			$display("tb_indexed_array_list_unit NOT OK");
		end
		$finish;
	end

endmodule
